[sv/tcmr_pkg.sv]
package tcmr_pkg;

   localparam int MAX_CITIES = 16;
   localparam int IDX_W      = $clog2(MAX_CITIES);
   localparam int SIDE_W     = IDX_W + 1;
   localparam int ADDR_W     = 2 * IDX_W;
   localparam int DEPTH      = MAX_CITIES * MAX_CITIES;
   localparam int VAL_W      = 10;
   localparam int COST_W     = 15;
   localparam int CMD_W      = 3;

   localparam logic [VAL_W-1:0] MARK = VAL_W'(999);

   localparam logic [CMD_W-1:0] CMD_WRITE    = 3'd0;
   localparam logic [CMD_W-1:0] CMD_READ     = 3'd1;
   localparam logic [CMD_W-1:0] CMD_NULL_ROW = 3'd2;
   localparam logic [CMD_W-1:0] CMD_NULL_COL = 3'd3;
   localparam logic [CMD_W-1:0] CMD_MEASURE  = 3'd4;
   localparam logic [CMD_W-1:0] CMD_APPLY    = 3'd5;

   typedef struct packed {
      logic [CMD_W-1:0] cmd;
      logic [IDX_W-1:0] row;
      logic [IDX_W-1:0] col;
      logic [IDX_W-1:0] line;
      logic [VAL_W-1:0] value;
   } req_type;

   typedef struct packed {
      logic [VAL_W-1:0]  read_value;
      logic [COST_W-1:0] reduction_cost;
      logic              already_reduced;
      logic              index_error;
   } rsp_type;

   typedef struct packed {
      logic              we;
      logic [ADDR_W-1:0] waddr;
      logic [VAL_W-1:0]  wdata;
      logic [ADDR_W-1:0] raddr;
   } mem_type;

   typedef struct packed {
      logic ready;
      logic done;
   } stat_type;

endpackage

[sv/tcmr_ram.sv]
module tcmr_ram #(
   parameter int WIDTH = 10,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[sv/tcmr_engine.sv]
module tcmr_engine (
   input  logic                     clock,
   input  logic                     reset,
   input  logic [tcmr_pkg::SIDE_W-1:0] city_count,
   input  logic                     start,
   input  tcmr_pkg::req_type        req,
   input  logic                     out_free,
   output tcmr_pkg::stat_type       stat,
   output tcmr_pkg::rsp_type        res,
   output tcmr_pkg::mem_type        cost_mem,
   input  logic [tcmr_pkg::VAL_W-1:0] cost_rdata,
   output tcmr_pkg::mem_type        scr_mem,
   input  logic [tcmr_pkg::VAL_W-1:0] scr_rdata
);

   import tcmr_pkg::*;

   localparam logic [3:0] S_IDLE   = 4'd0;
   localparam logic [3:0] S_EXEC   = 4'd1;
   localparam logic [3:0] S_RDATA  = 4'd2;
   localparam logic [3:0] S_NULL   = 4'd3;
   localparam logic [3:0] S_RMIN   = 4'd4;
   localparam logic [3:0] S_RSUB   = 4'd5;
   localparam logic [3:0] S_RDRAIN = 4'd6;
   localparam logic [3:0] S_CSUM   = 4'd7;
   localparam logic [3:0] S_CSUB   = 4'd8;
   localparam logic [3:0] S_DONE   = 4'd9;

   localparam logic [1:0] K_MIN  = 2'd0;
   localparam logic [1:0] K_RSUB = 2'd1;
   localparam logic [1:0] K_CSUB = 2'd2;

   logic [3:0]        state_ff, state_in;
   req_type           req_ff, req_in;
   rsp_type           res_ff, res_in;
   logic [IDX_W-1:0]  a_ff, a_in, t_ff, t_in;
   logic [VAL_W-1:0]  min_ff, min_in, cmin_ff, cmin_in;
   logic [COST_W-1:0] cost_ff, cost_in;
   logic              all_zero_ff, all_zero_in;
   logic [VAL_W-1:0]  colmin_ff [MAX_CITIES];
   logic [VAL_W-1:0]  colmin_in [MAX_CITIES];
   logic [MAX_CITIES-1:0] col_zero_ff, col_zero_in;
   logic              pend_ff, pend_in;
   logic [1:0]        pkind_ff, pkind_in;
   logic [IDX_W-1:0]  pa_ff, pa_in, pt_ff, pt_in;

   logic [SIDE_W-1:0] n_side, n_m1;
   logic [IDX_W-1:0]  last_idx, cm_idx;
   logic              t_last, a_last, entry_bad, line_bad, is_reduce;
   logic [VAL_W-1:0]  pv, base_min, m_eff, sub_val, cm_rd, base_cm, sat_val;

   assign n_side   = (city_count < SIDE_W'(2)) ? SIDE_W'(2) :
                     (city_count > SIDE_W'(MAX_CITIES)) ? SIDE_W'(MAX_CITIES) : city_count;
   assign n_m1     = n_side - SIDE_W'(1);
   assign last_idx = n_m1[IDX_W-1:0];
   assign t_last   = (t_ff == last_idx);
   assign a_last   = (a_ff == last_idx);
   assign entry_bad = ({1'b0, req_ff.row} >= n_side) || ({1'b0, req_ff.col} >= n_side);
   assign line_bad  = ({1'b0, req_ff.line} >= n_side);
   assign is_reduce = (req_ff.cmd == CMD_MEASURE) || (req_ff.cmd == CMD_APPLY);
   assign sat_val   = (req_ff.value > MARK) ? MARK : req_ff.value;

   assign pv       = (pkind_ff == K_CSUB) ? scr_rdata : cost_rdata;
   assign base_min = (pt_ff == '0) ? MARK : min_ff;
   assign m_eff    = (pkind_ff == K_CSUB) ? ((cmin_ff == MARK) ? '0 : cmin_ff)
                                          : ((min_ff == MARK) ? '0 : min_ff);
   assign sub_val  = (pv == MARK) ? MARK : pv - m_eff;
   assign cm_idx   = (state_ff == S_CSUM) ? a_ff : pt_ff;
   assign cm_rd    = colmin_ff[cm_idx];
   assign base_cm  = (pa_ff == '0) ? MARK : cm_rd;

   always_comb begin
      state_in    = state_ff;
      req_in      = req_ff;
      res_in      = res_ff;
      a_in        = a_ff;
      t_in        = t_ff;
      min_in      = min_ff;
      cmin_in     = cmin_ff;
      cost_in     = cost_ff;
      all_zero_in = all_zero_ff;
      colmin_in   = colmin_ff;
      col_zero_in = col_zero_ff;
      pend_in     = 1'b0;
      pkind_in    = pkind_ff;
      pa_in       = pa_ff;
      pt_in       = pt_ff;
      stat.ready  = (state_ff == S_IDLE);
      stat.done   = 1'b0;
      cost_mem    = '{we: 1'b0, waddr: {a_ff, t_ff}, wdata: MARK, raddr: {a_ff, t_ff}};
      scr_mem     = '{we: 1'b0, waddr: {pa_ff, pt_ff}, wdata: sub_val, raddr: {t_ff, a_ff}};

      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               req_in   = req;
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            res_in   = '0;
            state_in = S_DONE;
            unique case (req_ff.cmd)
               CMD_WRITE: begin
                  if (entry_bad) begin
                     res_in.index_error = 1'b1;
                  end else begin
                     cost_mem.we    = 1'b1;
                     cost_mem.waddr = {req_ff.row, req_ff.col};
                     cost_mem.wdata = sat_val;
                  end
               end
               CMD_READ: begin
                  if (entry_bad) begin
                     res_in.index_error = 1'b1;
                  end else begin
                     cost_mem.raddr = {req_ff.row, req_ff.col};
                     state_in       = S_RDATA;
                  end
               end
               CMD_NULL_ROW, CMD_NULL_COL: begin
                  if (line_bad) begin
                     res_in.index_error = 1'b1;
                  end else begin
                     t_in     = '0;
                     state_in = S_NULL;
                  end
               end
               CMD_MEASURE, CMD_APPLY: begin
                  a_in        = '0;
                  t_in        = '0;
                  cost_in     = '0;
                  all_zero_in = 1'b1;
                  state_in    = S_RMIN;
               end
               default: begin
               end
            endcase
         end
         S_RDATA: begin
            res_in.read_value = cost_rdata;
            state_in          = S_DONE;
         end
         S_NULL: begin
            cost_mem.we    = 1'b1;
            cost_mem.waddr = (req_ff.cmd == CMD_NULL_ROW) ? {req_ff.line, t_ff}
                                                          : {t_ff, req_ff.line};
            t_in = t_ff + 1'b1;
            if (t_last) begin
               state_in = S_DONE;
            end
         end
         S_RMIN, S_RSUB: begin
            pend_in  = 1'b1;
            pkind_in = (state_ff == S_RMIN) ? K_MIN : K_RSUB;
            pa_in    = a_ff;
            pt_in    = t_ff;
            t_in     = t_ff + 1'b1;
            if (t_last) begin
               t_in = '0;
               if (state_ff == S_RMIN) begin
                  state_in = S_RSUB;
               end else if (a_last) begin
                  state_in = S_RDRAIN;
               end else begin
                  a_in     = a_ff + 1'b1;
                  state_in = S_RMIN;
               end
            end
         end
         S_RDRAIN: begin
            a_in     = '0;
            state_in = S_CSUM;
         end
         S_CSUM: begin
            if (cm_rd != '0 && cm_rd != MARK) begin
               cost_in = cost_ff + COST_W'(cm_rd);
            end
            all_zero_in = all_zero_ff & col_zero_ff[a_ff];
            cmin_in     = cm_rd;
            if (req_ff.cmd == CMD_APPLY) begin
               t_in     = '0;
               state_in = S_CSUB;
            end else if (a_last) begin
               state_in = S_DONE;
            end else begin
               a_in = a_ff + 1'b1;
            end
            res_in.reduction_cost  = cost_in;
            res_in.already_reduced = all_zero_in;
         end
         S_CSUB: begin
            pend_in  = 1'b1;
            pkind_in = K_CSUB;
            pa_in    = a_ff;
            pt_in    = t_ff;
            t_in     = t_ff + 1'b1;
            if (t_last) begin
               t_in = '0;
               if (a_last) begin
                  state_in = S_DONE;
               end else begin
                  a_in     = a_ff + 1'b1;
                  state_in = S_CSUM;
               end
            end
         end
         S_DONE: begin
            if (!is_reduce) begin
               res_in.reduction_cost  = '0;
               res_in.already_reduced = 1'b0;
            end
            stat.done = out_free;
            if (out_free) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      if (pend_ff) begin
         unique case (pkind_ff)
            K_MIN: begin
               min_in = (pv != MARK && pv < base_min) ? pv : base_min;
               col_zero_in[pt_ff] = ((pa_ff == '0) ? 1'b0 : col_zero_ff[pt_ff]) | (pv == '0);
            end
            K_RSUB: begin
               scr_mem.we = 1'b1;
               colmin_in[pt_ff] = (sub_val != MARK && sub_val < base_cm) ? sub_val : base_cm;
               if (pt_ff == '0) begin
                  if (min_ff != '0 && min_ff != MARK) begin
                     cost_in = cost_ff + COST_W'(min_ff);
                  end
                  all_zero_in = all_zero_ff & (min_ff == '0);
               end
            end
            K_CSUB: begin
               cost_mem.we    = 1'b1;
               cost_mem.waddr = {pt_ff, pa_ff};
               cost_mem.wdata = sub_val;
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         pend_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         pend_ff  <= pend_in;
      end
      req_ff      <= req_in;
      res_ff      <= res_in;
      a_ff        <= a_in;
      t_ff        <= t_in;
      min_ff      <= min_in;
      cmin_ff     <= cmin_in;
      cost_ff     <= cost_in;
      all_zero_ff <= all_zero_in;
      colmin_ff   <= colmin_in;
      col_zero_ff <= col_zero_in;
      pkind_ff    <= pkind_in;
      pa_ff       <= pa_in;
      pt_ff       <= pt_in;
   end

   always_comb begin
      res = res_ff;
      if (!is_reduce) begin
         res.reduction_cost  = '0;
         res.already_reduced = 1'b0;
      end
   end

endmodule

[sv/tsp_cost_matrix_reducer_unit.sv]
// n = clamped city count (2 to 16). Write, error and unused codes finish directly; read
//   waits on the registered memory read; null row/column writes MARK into n entries;
//   reduce measure sums row and column minima; apply also writes the reduced matrix back.
// One request at a time; the next request is taken the cycle after the result registers.
// Matrix contents are not reset; reset is synchronous, active high, and restores city
// count 16 and an idle engine.
module tsp_cost_matrix_reducer_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_wr_en,
   input  logic [4:0]  csr_wr_data,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,   // row[3:0], col[7:4], line[11:8], value[21:12], zero
   input  logic [2:0]  req_tuser,   // cmd[2:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // read_value[9:0], reduction_cost[24:10], zero
   output logic [1:0]  rsp_tuser    // already_reduced[0], index_error[1]
);

   import tcmr_pkg::*;

   logic [SIDE_W-1:0] city_count_ff, city_count_in;
   logic              rsp_tvalid_ff, rsp_tvalid_in;
   rsp_type           rsp_ff, rsp_in;
   req_type           req;
   rsp_type           res;
   stat_type          stat;
   mem_type           cost_mem, scr_mem;
   logic [VAL_W-1:0]  cost_rdata, scr_rdata;
   logic              start, out_free;

   assign req.cmd   = req_tuser;
   assign req.row   = req_tdata[3:0];
   assign req.col   = req_tdata[7:4];
   assign req.line  = req_tdata[11:8];
   assign req.value = req_tdata[21:12];

   assign req_tready = stat.ready;
   assign start      = req_tvalid & stat.ready;
   assign out_free   = !rsp_tvalid_ff || rsp_tready;

   always_comb begin
      city_count_in = csr_wr_en ? csr_wr_data : city_count_ff;
      rsp_in        = stat.done ? res : rsp_ff;
      rsp_tvalid_in = stat.done ? 1'b1 : (rsp_tready ? 1'b0 : rsp_tvalid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         city_count_ff <= SIDE_W'(MAX_CITIES);
         rsp_tvalid_ff <= 1'b0;
      end else begin
         city_count_ff <= city_count_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
      rsp_ff <= rsp_in;
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = {7'b0, rsp_ff.reduction_cost, rsp_ff.read_value};
   assign rsp_tuser  = {rsp_ff.index_error, rsp_ff.already_reduced};

   tcmr_engine u_engine (
      .clock      (clock),
      .reset      (reset),
      .city_count (city_count_ff),
      .start      (start),
      .req        (req),
      .out_free   (out_free),
      .stat       (stat),
      .res        (res),
      .cost_mem   (cost_mem),
      .cost_rdata (cost_rdata),
      .scr_mem    (scr_mem),
      .scr_rdata  (scr_rdata)
   );

   tcmr_ram #(.WIDTH(VAL_W), .DEPTH(DEPTH)) u_cost_ram (
      .clock   (clock),
      .wr_en   (cost_mem.we),
      .wr_addr (cost_mem.waddr),
      .wr_data (cost_mem.wdata),
      .rd_addr (cost_mem.raddr),
      .rd_data (cost_rdata)
   );

   tcmr_ram #(.WIDTH(VAL_W), .DEPTH(DEPTH)) u_scr_ram (
      .clock   (clock),
      .wr_en   (scr_mem.we),
      .wr_addr (scr_mem.waddr),
      .wr_data (scr_mem.wdata),
      .rd_addr (scr_mem.raddr),
      .rd_data (scr_rdata)
   );

endmodule

[sv/tcmr_checker.sv]
module tcmr_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [31:0] rsp_tdata,
   input logic [1:0]  rsp_tuser
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("response changed while stalled");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("request taken while busy");

   a_error_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[1] |-> rsp_tdata == 32'd0 && !rsp_tuser[0])
      else $error("error response carries data");

   a_reduced_no_cost: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[0] |-> rsp_tdata[24:10] == 15'd0 && rsp_tdata[9:0] == 10'd0)
      else $error("reduced matrix reports a cost");

endmodule

bind tsp_cost_matrix_reducer_unit tcmr_checker u_tcmr_checker (.*);
